// File: hw/rtl/pyro_trigger_sequencer_unit_defines.svh
// Assertion macros for the pyro trigger sequencer unit.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PYRO_TRIGGER_SEQUENCER_UNIT_DEFINES_SVH
`define PYRO_TRIGGER_SEQUENCER_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pts_pkg.sv
// Shared types and constants of the pyro trigger sequencer.
// No dependencies.
package pts_pkg;

  localparam int unsigned DeltaW  = 16;
  localparam int unsigned TsW     = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned AttW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDatW = 40;
  localparam int unsigned MaxCmds = 3;

  localparam logic [15:0] SlowPeriodRst    = 16'd2000;
  localparam logic [15:0] NormalPeriodRst  = 16'd1000;
  localparam logic [15:0] PostSepPeriodRst = 16'd500;
  localparam logic [15:0] AscentPeriodRst  = 16'd100;
  localparam logic [15:0] WakeRetryRst     = 16'd500;
  localparam logic [7:0]  MaxWakeRst       = 8'd10;
  localparam logic [15:0] FireRst          = 16'd400;
  localparam logic [15:0] AckWaitRst       = 16'd200;

  localparam logic [1:0] ChMain  = 2'd0;
  localparam logic [1:0] ChSpare1 = 2'd1;
  localparam logic [1:0] ChSpare2 = 2'd2;

  typedef enum logic [3:0] {
    FS_INIT     = 4'd0,
    FS_CALIB    = 4'd1,
    FS_FILLING  = 4'd2,
    FS_ARMED    = 4'd3,
    FS_PRESS    = 4'd4,
    FS_IGNITION = 4'd5,
    FS_BURN     = 4'd6,
    FS_ASCENT   = 4'd7,
    FS_DESCENT  = 4'd8,
    FS_LANDED   = 4'd9,
    FS_ABORT_G  = 4'd10,
    FS_ABORT_F  = 4'd11
  } flight_e;

  typedef enum logic [2:0] {
    ACT_TIMESTAMP = 3'd0,
    ACT_WAKE      = 3'd1,
    ACT_RD_WOKEN  = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_PYROS     = 3'd4,
    ACT_RD_TRIG   = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOW     = 3'd0,
    CFG_NORMAL   = 3'd1,
    CFG_POST_SEP = 3'd2,
    CFG_ASCENT   = 3'd3,
    CFG_WAKE     = 3'd4,
    CFG_MAX_WAKE = 3'd5,
    CFG_FIRE     = 3'd6,
    CFG_ACK      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] slow_period_ms;
    logic [15:0] normal_period_ms;
    logic [15:0] post_sep_period_ms;
    logic [15:0] ascent_period_ms;
    logic [15:0] wake_retry_ms;
    logic [7:0]  max_wake_attempts;
    logic [15:0] fire_ms;
    logic [15:0] ack_wait_ms;
  } cfg_t;

  // first field in the highest bits
  typedef struct packed {
    logic              separated;
    logic              board_ready;
    logic              lox_pressure_ok;
    logic              eth_pressure_ok;
    logic [TsW-1:0]    timestamp;
    logic [DeltaW-1:0] elapsed_ms;
    logic [3:0]        flight_state;
  } item_t;

  typedef struct packed {
    action_e        action;
    logic [TsW-1:0] payload;
    logic [1:0]     pyro_channel;
    logic           level_on;
  } cmd_t;

  typedef struct packed {
    cmd_t [MaxCmds-1:0] cmd;
    logic [1:0]         cnt;
    logic               wake_failed;
  } batch_t;

endpackage

// File: hw/rtl/pyro_trigger_sequencer_unit.sv
// Pyro trigger sequencer unit: top level with input register and stream ports.
// Depends on pts_pkg, pts_cfg, pts_core and pts_emit.
// A tick request enters an input register; when the result register is free
// (empty, or handing off its last command in that cycle) the tick is evaluated
// and its zero to three commands are loaded into the result register. Commands
// leave one per cycle while the output is ready. A tick is taken every cycle
// while the output is ready, as long as each produces at most one command; a
// tick with more commands holds the single output port until all have left.
// Config writes are always ready.
module pyro_trigger_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // flight_state[3:0], elapsed_ms[19:4], timestamp[51:20], eth_pressure_ok[52],
  // lox_pressure_ok[53], board_ready[54], separated[55]
  input  logic [pts_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // payload[31:0], pyro_channel[33:32], level_on[34], wake_failed[35], zero[39:36]
  output logic [pts_pkg::OutDatW-1:0]   m_axis_tdata,
  // action[2:0]
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pts_pkg::CfgDatW-1:0]   cfg_data_i
);

  pts_pkg::item_t  item_q;
  pts_pkg::cfg_t   cfg;
  pts_pkg::batch_t batch;
  pts_pkg::cmd_t   cmd;
  logic            in_valid_q, step, free, wake_failed;

  assign step          = in_valid_q && free;
  assign s_axis_tready = !in_valid_q || free;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= pts_pkg::item_t'(s_axis_tdata);
    end
  end

  pts_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pts_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .batch_o (batch)
  );

  pts_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step && (batch.cnt != 2'd0)),
    .batch_i       (batch),
    .free_o        (free),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .cmd_o         (cmd),
    .wake_failed_o (wake_failed),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, wake_failed, cmd.level_on, cmd.pyro_channel, cmd.payload};
  assign m_axis_tuser = cmd.action;

endmodule

// File: hw/rtl/pts_cfg.sv
// Configuration register file of the pyro trigger sequencer.
// Depends on pts_pkg.
module pts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [pts_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [pts_pkg::CfgDatW-1:0]   data_i,
  output pts_pkg::cfg_t                 cfg_o
);

  pts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (pts_pkg::cfg_idx_e'(idx_i))
        pts_pkg::CFG_SLOW:     cfg_d.slow_period_ms     = data_i;
        pts_pkg::CFG_NORMAL:   cfg_d.normal_period_ms   = data_i;
        pts_pkg::CFG_POST_SEP: cfg_d.post_sep_period_ms = data_i;
        pts_pkg::CFG_ASCENT:   cfg_d.ascent_period_ms   = data_i;
        pts_pkg::CFG_WAKE:     cfg_d.wake_retry_ms      = data_i;
        pts_pkg::CFG_MAX_WAKE: cfg_d.max_wake_attempts  = data_i[7:0];
        pts_pkg::CFG_FIRE:     cfg_d.fire_ms            = data_i;
        pts_pkg::CFG_ACK:      cfg_d.ack_wait_ms        = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_period_ms     <= pts_pkg::SlowPeriodRst;
      cfg_q.normal_period_ms   <= pts_pkg::NormalPeriodRst;
      cfg_q.post_sep_period_ms <= pts_pkg::PostSepPeriodRst;
      cfg_q.ascent_period_ms   <= pts_pkg::AscentPeriodRst;
      cfg_q.wake_retry_ms      <= pts_pkg::WakeRetryRst;
      cfg_q.max_wake_attempts  <= pts_pkg::MaxWakeRst;
      cfg_q.fire_ms            <= pts_pkg::FireRst;
      cfg_q.ack_wait_ms        <= pts_pkg::AckWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pts_core.sv
// Tick evaluation: timers, wake retries and pyro sequencing for one tick.
// Depends on pts_pkg and the assertion macro header.
`include "pyro_trigger_sequencer_unit_defines.svh"

module pts_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  pts_pkg::item_t  item_i,
  input  pts_pkg::cfg_t   cfg_i,
  output pts_pkg::batch_t batch_o
);

  localparam int unsigned CW = pts_pkg::CountW;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a,
                                           logic [pts_pkg::DeltaW-1:0] d);
    logic [CW:0] s;
    s = {1'b0, a} + {{(CW + 1 - pts_pkg::DeltaW){1'b0}}, d};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  logic [CW-1:0]             pc_q, pc_d, wc_q, wc_d, fc_q, fc_d, ac_q, ac_d;
  logic [pts_pkg::AttW-1:0]  att_q, att_d;
  logic                      main_f_q, main_f_d, sp1_f_q, sp1_f_d, sp2_f_q, sp2_f_d;
  logic [CW-1:0]             pc_sum, wc_sum, fc_sum, ac_sum;
  logic [15:0]               period;
  logic                      periodic, ascent, armed, descent;
  logic [1:0]                n, chan;
  pts_pkg::cmd_t             ts_cmd;
  pts_pkg::batch_t           batch;

  assign pc_sum = sat_add(pc_q, item_i.elapsed_ms);
  assign wc_sum = sat_add(wc_q, item_i.elapsed_ms);
  assign fc_sum = sat_add(fc_q, item_i.elapsed_ms);
  assign ac_sum = sat_add(ac_q, item_i.elapsed_ms);

  assign chan = !main_f_q ? pts_pkg::ChMain : (!sp1_f_q ? pts_pkg::ChSpare1 : pts_pkg::ChSpare2);

  always_comb begin
    ts_cmd.action       = pts_pkg::ACT_TIMESTAMP;
    ts_cmd.payload      = item_i.timestamp;
    ts_cmd.pyro_channel = pts_pkg::ChMain;
    ts_cmd.level_on     = 1'b0;
  end

  always_comb begin
    pc_d = pc_q;
    wc_d = wc_q;
    fc_d = fc_q;
    ac_d = ac_q;
    att_d = att_q;
    main_f_d = main_f_q;
    sp1_f_d = sp1_f_q;
    sp2_f_d = sp2_f_q;
    batch = '0;
    n = 2'd0;
    period = cfg_i.normal_period_ms;
    periodic = 1'b0;
    ascent = 1'b0;
    armed = 1'b0;
    descent = 1'b0;

    case (pts_pkg::flight_e'(item_i.flight_state))
      pts_pkg::FS_INIT, pts_pkg::FS_CALIB: begin
        period = cfg_i.slow_period_ms;
        periodic = 1'b1;
      end
      pts_pkg::FS_FILLING, pts_pkg::FS_PRESS, pts_pkg::FS_IGNITION, pts_pkg::FS_BURN,
      pts_pkg::FS_LANDED, pts_pkg::FS_ABORT_G, pts_pkg::FS_ABORT_F: begin
        periodic = 1'b1;
      end
      pts_pkg::FS_ARMED: begin
        periodic = 1'b1;
        armed = 1'b1;
      end
      pts_pkg::FS_ASCENT: begin
        period = cfg_i.ascent_period_ms;
        periodic = 1'b1;
        ascent = 1'b1;
      end
      pts_pkg::FS_DESCENT: begin
        if (item_i.separated) begin
          period = cfg_i.post_sep_period_ms;
          periodic = 1'b1;
        end else begin
          descent = 1'b1;
        end
      end
      default: ;
    endcase

    if (periodic) begin
      if (pc_sum >= {{(CW - 16){1'b0}}, period}) begin
        batch.cmd[n] = ts_cmd;
        n = n + 2'd1;
        if (ascent) begin
          batch.cmd[n].action   = pts_pkg::ACT_CLEAR;
          batch.cmd[n].level_on = 1'b1;
          n = n + 2'd1;
        end
        pc_d = '0;
      end else begin
        pc_d = pc_sum;
      end
    end

    if (armed && item_i.eth_pressure_ok && item_i.lox_pressure_ok && !item_i.board_ready) begin
      if (wc_sum >= {{(CW - 16){1'b0}}, cfg_i.wake_retry_ms}) begin
        batch.cmd[n].action = pts_pkg::ACT_WAKE;
        n = n + 2'd1;
        batch.cmd[n].action = pts_pkg::ACT_RD_WOKEN;
        n = n + 2'd1;
        wc_d = '0;
        if (att_q != {pts_pkg::AttW{1'b1}}) begin
          att_d = att_q + 1'b1;
        end
      end else begin
        wc_d = wc_sum;
      end
    end

    if (descent) begin
      batch.cmd[n] = ts_cmd;
      n = n + 2'd1;
      if (fc_q < {{(CW - 16){1'b0}}, cfg_i.fire_ms}) begin
        batch.cmd[n].action       = pts_pkg::ACT_PYROS;
        batch.cmd[n].pyro_channel = chan;
        batch.cmd[n].level_on     = 1'b1;
        n = n + 2'd1;
        fc_d = fc_sum;
      end else begin
        batch.cmd[n].action = pts_pkg::ACT_RD_TRIG;
        n = n + 2'd1;
        batch.cmd[n].action       = pts_pkg::ACT_PYROS;
        batch.cmd[n].pyro_channel = chan;
        n = n + 2'd1;
        if (ac_sum >= {{(CW - 16){1'b0}}, cfg_i.ack_wait_ms}) begin
          case (chan)
            pts_pkg::ChMain:   main_f_d = 1'b1;
            pts_pkg::ChSpare1: sp1_f_d = 1'b1;
            default:           sp2_f_d = 1'b1;
          endcase
          fc_d = '0;
          ac_d = '0;
        end else begin
          ac_d = ac_sum;
        end
      end
    end

    batch.cnt = n;
    batch.wake_failed = att_d > cfg_i.max_wake_attempts;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      wc_q <= '0;
      fc_q <= '0;
      ac_q <= '0;
      att_q <= '0;
      main_f_q <= 1'b0;
      sp1_f_q <= 1'b0;
      sp2_f_q <= 1'b0;
    end else if (step_i) begin
      pc_q <= pc_d;
      wc_q <= wc_d;
      fc_q <= fc_d;
      ac_q <= ac_d;
      att_q <= att_d;
      main_f_q <= main_f_d;
      sp1_f_q <= sp1_f_d;
      sp2_f_q <= sp2_f_d;
    end
  end

  assign batch_o = batch;

  `PTS_ASSERT_NEXT(a_main_sticky, main_f_q, main_f_q, "main failure flag cleared")
  `PTS_ASSERT(a_spare_order, !sp1_f_q || main_f_q, "spare one failed before main")
  `PTS_ASSERT(a_spare2_order, !sp2_f_q || sp1_f_q, "spare two failed before spare one")

endmodule

// File: hw/rtl/pts_emit.sv
// Result register: holds the commands of one tick and issues one per cycle while the output is ready.
// Depends on pts_pkg and the assertion macro header.
`include "pyro_trigger_sequencer_unit_defines.svh"

module pts_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  pts_pkg::batch_t batch_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output pts_pkg::cmd_t   cmd_o,
  output logic            wake_failed_o,
  output logic            last_o
);

  pts_pkg::cmd_t [pts_pkg::MaxCmds-1:0] cmd_q;
  logic [1:0] cnt_q, idx_q;
  logic       wf_q, pop;

  assign valid_o       = cnt_q != 2'd0;
  assign last_o        = idx_q == cnt_q - 2'd1;
  assign pop           = valid_o && ready_i;
  assign free_o        = !valid_o || (pop && last_o);
  assign cmd_o         = cmd_q[idx_q];
  assign wake_failed_o = wf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
      idx_q <= 2'd0;
    end else if (pop) begin
      if (last_o) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q <= batch_i.cmd;
      wf_q  <= batch_i.wake_failed;
    end
  end

  `PTS_ASSERT(a_idx_range, !valid_o || (idx_q < cnt_q), "command index past count")
  `PTS_ASSERT(a_load_free, !load_i || free_o, "batch loaded over pending commands")
  `PTS_ASSERT_NEXT(a_drain, pop && last_o && !load_i, !valid_o, "extra command after last")

endmodule
